FILE: src/dsfa_pkg.sv
// ----------------------------------------------------------------------------
// dsfa_pkg: shared types and constants of the flood alarm
// Field widths, config register indexes and the item, config and result
// records passed between the stream wrapper and the alarm state machine.
// ----------------------------------------------------------------------------
package dsfa_pkg;

    // field and timer widths
    localparam int TIME_W       = 32;
    localparam int LEVEL_W      = 16;
    localparam int THRESH_W     = 15;
    localparam int DELAY_W      = 16;
    localparam int MS_PER_S     = 1000;
    localparam int DELAY_MS_W   = 26;
    localparam int STATE_W      = 4;
    localparam int COLOUR_W     = 2;
    localparam int RISE_STEP_MM = 60;
    localparam int JUMP_STEP_MM = 30;

    // stream and config port widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_LEVEL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SENSOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_SENSOR  = 3'd7;

    // status colour classes
    localparam logic [COLOUR_W-1:0] COL_NORMAL = 2'd0;
    localparam logic [COLOUR_W-1:0] COL_ORANGE = 2'd1;
    localparam logic [COLOUR_W-1:0] COL_DANGER = 2'd2;
    localparam logic [COLOUR_W-1:0] COL_FAULT  = 2'd3;

    // configuration, delays already scaled to milliseconds
    typedef struct packed {
        logic [DELAY_MS_W-1:0] trigger_ms;
        logic [DELAY_MS_W-1:0] clear_ms;
        logic [DELAY_MS_W-1:0] mismatch_ms;
        logic [THRESH_W-1:0]   alert_level_mm;
        logic [THRESH_W-1:0]   danger_level_mm;
        logic [THRESH_W-1:0]   clear_level_mm;
        logic                  level_sensor_on;
        logic                  switch_sensor_on;
    } cfg_t;

    // one input word
    typedef struct packed {
        logic                      func;
        logic                      mute_value;
        logic [TIME_W-1:0]         now_ms;
        logic signed [LEVEL_W-1:0] water_level_mm;
        logic                      sensor_enabled;
        logic                      sensor_error;
        logic                      sensor_valid;
        logic                      sensor_seen_valid;
        logic                      switch_low_closed;
        logic                      switch_high_closed;
    } item_t;

    // one result word
    typedef struct packed {
        logic [STATE_W-1:0]  alarm_state;
        logic [COLOUR_W-1:0] status_colour;
        logic                danger_active;
        logic                alert_active;
        logic                muted_now;
        logic                switch_fault_event;
        logic                obstruction_event;
    } result_t;

endpackage

FILE: src/dual_sensor_flood_alarm.sv
// ----------------------------------------------------------------------------
// dual_sensor_flood_alarm: flood alarm with level sensor and float switches
// Path: an accepted word is held in the input word register, then the alarm
// step registers its result, which drives m_tdata and m_tvalid.
// Throughput: one word per cycle while m_tready holds; the alarm step is a single registered pass.
// Reset: rst_n clears the alarm to normal, all timers unarmed, flags and
// config registers to zero; both stream sides come up empty.
// ----------------------------------------------------------------------------
module dual_sensor_flood_alarm
    import dsfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mute_value[0], now_ms[32:1], water_level_mm[48:33], sensor_enabled[49],
    // sensor_error[50], sensor_valid[51], sensor_seen_valid[52],
    // switch_low_closed[53], switch_high_closed[54], zero[55]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func[0]
    input  logic                   s_tuser,
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // alarm_state[3:0], status_colour[5:4], danger_active[6], alert_active[7],
    // muted_now[8], switch_fault_event[9], obstruction_event[10], zero[15:11]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    step;
    logic    in_take;
    result_t result;

    // pipeline flow
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // config registers, delays scaled to ms on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TRIGGER_DELAY:
                    cfg_reg.trigger_ms <= DELAY_MS_W'(cfg_data[DELAY_W-1:0])
                                          * DELAY_MS_W'(MS_PER_S);
                CFG_CLEAR_DELAY:
                    cfg_reg.clear_ms <= DELAY_MS_W'(cfg_data[DELAY_W-1:0])
                                        * DELAY_MS_W'(MS_PER_S);
                CFG_MISMATCH_DELAY:
                    cfg_reg.mismatch_ms <= DELAY_MS_W'(cfg_data[DELAY_W-1:0])
                                           * DELAY_MS_W'(MS_PER_S);
                CFG_ALERT_LEVEL:   cfg_reg.alert_level_mm   <= cfg_data[THRESH_W-1:0];
                CFG_DANGER_LEVEL:  cfg_reg.danger_level_mm  <= cfg_data[THRESH_W-1:0];
                CFG_CLEAR_LEVEL:   cfg_reg.clear_level_mm   <= cfg_data[THRESH_W-1:0];
                CFG_LEVEL_SENSOR:  cfg_reg.level_sensor_on  <= cfg_data[0];
                CFG_SWITCH_SENSOR: cfg_reg.switch_sensor_on <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end
            else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            item_reg.func               <= s_tuser;
            item_reg.mute_value         <= s_tdata[0];
            item_reg.now_ms             <= s_tdata[32:1];
            item_reg.water_level_mm     <= s_tdata[48:33];
            item_reg.sensor_enabled     <= s_tdata[49];
            item_reg.sensor_error       <= s_tdata[50];
            item_reg.sensor_valid       <= s_tdata[51];
            item_reg.sensor_seen_valid  <= s_tdata[52];
            item_reg.switch_low_closed  <= s_tdata[53];
            item_reg.switch_high_closed <= s_tdata[54];
        end
    end

    // alarm state machine and result register
    dsfa_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // output word packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       result.obstruction_event,
                       result.switch_fault_event,
                       result.muted_now,
                       result.alert_active,
                       result.danger_active,
                       result.status_colour,
                       result.alarm_state};

`ifndef SYNTH
    // a processed word always lands in the output register
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed word not presented");
`endif

endmodule

FILE: src/dsfa_fsm.sv
// ----------------------------------------------------------------------------
// dsfa_fsm: flood alarm state machine
// Per step applies a set-mute word or qualifies one sample against the level and
// switch sensors, runs the trigger, clear and mismatch timers and registers the result word.
// ----------------------------------------------------------------------------
module dsfa_fsm
    import dsfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    typedef enum logic [STATE_W-1:0] {
        ST_NORMAL             = 4'd0,
        ST_FAULT              = 4'd1,
        ST_CLEAR_PEND         = 4'd2,
        ST_DANGER_PEND        = 4'd3,
        ST_DANGER_CONFIRMED   = 4'd4,
        ST_DANGER_MISMATCH    = 4'd5,
        ST_DANGER_SENSORFAULT = 4'd6,
        ST_ALERT_PEND         = 4'd7,
        ST_ALERT              = 4'd8,
        ST_ALERT_CONFIRMED    = 4'd9,
        ST_ALERT_MISMATCH     = 4'd10,
        ST_ALERT_SENSORFAULT  = 4'd11
    } alarm_t;

    typedef struct packed {
        logic [TIME_W-1:0] mark;
        logic              ok;
    } timer_t;

    localparam logic signed [LEVEL_W:0] RISE_LIM = (LEVEL_W+1)'(RISE_STEP_MM);
    localparam logic signed [LEVEL_W:0] JUMP_POS = (LEVEL_W+1)'(JUMP_STEP_MM);
    localparam logic signed [LEVEL_W:0] JUMP_NEG = (LEVEL_W+1)'(-JUMP_STEP_MM);

    // a zero mark means unarmed; arming stores now, so arming at zero stays unarmed
    function automatic timer_t timer_step(
        input logic                  cond,
        input logic [TIME_W-1:0]     mark,
        input logic [DELAY_MS_W-1:0] delay,
        input logic [TIME_W-1:0]     now
    );
        timer_t t;
        t.mark = mark;
        t.ok   = 1'b0;
        if (!cond) begin
            t.mark = '0;
        end
        else if (mark == '0) begin
            t.mark = now;
        end
        else begin
            t.ok = (now - mark) >= TIME_W'(delay);
        end
        return t;
    endfunction

    alarm_t                    code_reg, code_next;
    logic                      mute_reg, mute_next;
    logic [TIME_W-1:0]         alert_mark_reg, alert_mark_next;
    logic [TIME_W-1:0]         danger_mark_reg, danger_mark_next;
    logic [TIME_W-1:0]         clear_mark_reg, clear_mark_next;
    logic [TIME_W-1:0]         mis_mark_reg, mis_mark_next;
    logic                      swf_reg, swf_next;
    logic                      obs_reg, obs_next;
    logic signed [LEVEL_W-1:0] prev_reg, prev_next;
    result_t                   res_reg, res_next;

    logic                      lon, son;
    logic                      l1, l2;
    logic signed [LEVEL_W-1:0] lvl;
    logic [TIME_W-1:0]         now;
    logic                      lfault, lvalid;
    logic                      alert_x, danger_x, clear_x;
    logic signed [LEVEL_W:0]   diff;
    logic                      rising, unstable;
    logic                      danger_now;
    logic                      clear_cond;
    timer_t                    clear_t, danger_t, alert_t;
    logic [TIME_W-1:0]         mis_armed;
    logic                      mis_hit;

    // sample qualification
    assign lon    = cfg.level_sensor_on;
    assign son    = cfg.switch_sensor_on;
    assign l1     = son && item.switch_low_closed;
    assign l2     = son && item.switch_high_closed;
    assign lvl    = item.water_level_mm;
    assign now    = item.now_ms;
    assign lfault = lon && (!item.sensor_enabled || item.sensor_error || !item.sensor_valid);
    assign lvalid = lon && !lfault;

    // level thresholds, signed reading against unsigned registers
    assign alert_x  = lvalid && (lvl >= $signed({1'b0, cfg.alert_level_mm}));
    assign danger_x = lvalid && (lvl >= $signed({1'b0, cfg.danger_level_mm}));
    assign clear_x  = lvalid && (lvl < $signed({1'b0, cfg.clear_level_mm}));

    // step since last sample, for obstruction check
    assign diff     = {lvl[LEVEL_W-1], lvl} - {prev_reg[LEVEL_W-1], prev_reg};
    assign rising   = diff >= RISE_LIM;
    assign unstable = (lvl >= $signed({1'b0, cfg.danger_level_mm}))
                      && item.sensor_valid && item.sensor_seen_valid
                      && ((diff >= JUMP_POS) || (diff <= JUMP_NEG));

    assign danger_now = code_reg inside {ST_CLEAR_PEND, ST_DANGER_PEND, ST_DANGER_CONFIRMED,
                                         ST_DANGER_MISMATCH, ST_DANGER_SENSORFAULT};

    // clear condition per sensor mode
    always_comb
    begin
        if (lon && son) begin
            clear_cond = clear_x && !l1 && !l2;
        end
        else if (lon) begin
            clear_cond = clear_x;
        end
        else begin
            clear_cond = !l1 && !l2;
        end
    end

    // timers
    assign clear_t   = timer_step(clear_cond, clear_mark_reg, cfg.clear_ms, now);
    assign danger_t  = timer_step(1'b1, danger_mark_reg, cfg.trigger_ms, now);
    assign alert_t   = timer_step(1'b1, alert_mark_reg, cfg.trigger_ms, now);
    assign mis_armed = (mis_mark_reg == '0) ? now : mis_mark_reg;
    assign mis_hit   = (now - mis_armed) >= TIME_W'(cfg.mismatch_ms);

    // next state
    always_comb
    begin
        code_next        = code_reg;
        mute_next        = mute_reg;
        alert_mark_next  = alert_mark_reg;
        danger_mark_next = danger_mark_reg;
        clear_mark_next  = clear_mark_reg;
        mis_mark_next    = mis_mark_reg;
        swf_next         = swf_reg;
        obs_next         = obs_reg;
        prev_next        = prev_reg;

        if (item.func) begin
            // set-mute word
            mute_next = item.mute_value && danger_now;
        end
        else begin
            prev_next = lvl;
            if (!lon && !son) begin
                code_next = ST_FAULT;
            end
            else if (danger_now && clear_cond) begin
                clear_mark_next = clear_t.mark;
                if (clear_t.ok) begin
                    mute_next = 1'b0;
                    code_next = ST_NORMAL;
                end
                else begin
                    code_next = ST_CLEAR_PEND;
                end
            end
            else begin
                if (danger_now) begin
                    clear_mark_next = '0;
                end

                if (lon && !son) begin
                    // level sensor only
                    if (lfault) begin
                        code_next = ST_FAULT;
                    end
                    else if (danger_x) begin
                        danger_mark_next = danger_t.mark;
                        code_next = danger_t.ok ? ST_DANGER_CONFIRMED : ST_DANGER_PEND;
                    end
                    else begin
                        danger_mark_next = '0;
                        if (alert_x) begin
                            alert_mark_next = alert_t.mark;
                            code_next = alert_t.ok ? ST_ALERT : ST_ALERT_PEND;
                        end
                        else begin
                            alert_mark_next = '0;
                            code_next = ST_NORMAL;
                        end
                    end
                end
                else if (!lon) begin
                    // switches only
                    if (l2) begin
                        danger_mark_next = danger_t.mark;
                        code_next = danger_t.ok ? ST_DANGER_CONFIRMED : ST_DANGER_PEND;
                    end
                    else begin
                        danger_mark_next = '0;
                        if (l1) begin
                            alert_mark_next = alert_t.mark;
                            code_next = alert_t.ok ? ST_ALERT : ST_ALERT_PEND;
                        end
                        else begin
                            alert_mark_next = '0;
                            code_next = ST_NORMAL;
                        end
                    end
                end
                else if (lfault) begin
                    // dual mode, level sensor faulted: switches carry on
                    if (l2) begin
                        danger_mark_next = danger_t.mark;
                        code_next = danger_t.ok ? ST_DANGER_SENSORFAULT : ST_DANGER_PEND;
                    end
                    else begin
                        danger_mark_next = '0;
                        if (l1) begin
                            alert_mark_next = alert_t.mark;
                            code_next = alert_t.ok ? ST_ALERT_SENSORFAULT : ST_ALERT_PEND;
                        end
                        else begin
                            alert_mark_next = '0;
                            code_next = ST_FAULT;
                        end
                    end
                end
                else if (danger_x || l2) begin
                    // dual mode danger, cross-checked against the high switch
                    danger_mark_next = danger_t.mark;
                    if (danger_t.ok) begin
                        if (danger_x && l2) begin
                            code_next     = ST_DANGER_CONFIRMED;
                            mis_mark_next = '0;
                            swf_next      = 1'b0;
                        end
                        else begin
                            code_next     = ST_DANGER_MISMATCH;
                            mis_mark_next = mis_armed;
                            if (!swf_reg && mis_hit) begin
                                swf_next = 1'b1;
                            end
                        end
                    end
                    else begin
                        code_next = ST_DANGER_PEND;
                    end
                    if (danger_x && !l2 && unstable && rising) begin
                        obs_next = 1'b1;
                    end
                end
                else begin
                    danger_mark_next = '0;
                    mis_mark_next    = '0;
                    swf_next         = 1'b0;
                    if (alert_x || l1) begin
                        alert_mark_next = alert_t.mark;
                        if (!alert_t.ok) begin
                            code_next = ST_ALERT_PEND;
                        end
                        else if (alert_x && l1) begin
                            code_next = ST_ALERT_CONFIRMED;
                        end
                        else if (l1) begin
                            code_next = ST_ALERT_MISMATCH;
                        end
                        else begin
                            code_next = ST_ALERT_PEND;
                        end
                    end
                    else begin
                        alert_mark_next = '0;
                        code_next       = ST_NORMAL;
                    end
                end
            end
        end
    end

    // result word from the next state
    always_comb
    begin
        res_next.alarm_state        = code_next;
        res_next.danger_active      = code_next inside {ST_CLEAR_PEND, ST_DANGER_PEND,
                                                        ST_DANGER_CONFIRMED, ST_DANGER_MISMATCH,
                                                        ST_DANGER_SENSORFAULT};
        res_next.alert_active       = code_next inside {ST_ALERT_PEND, ST_ALERT,
                                                        ST_ALERT_CONFIRMED, ST_ALERT_MISMATCH,
                                                        ST_ALERT_SENSORFAULT};
        res_next.muted_now          = mute_next;
        res_next.switch_fault_event = swf_next;
        res_next.obstruction_event  = obs_next;
        case (code_next)
            ST_NORMAL, ST_CLEAR_PEND:
                res_next.status_colour = COL_NORMAL;
            ST_FAULT:
                res_next.status_colour = COL_FAULT;
            ST_DANGER_PEND, ST_DANGER_CONFIRMED, ST_DANGER_MISMATCH, ST_DANGER_SENSORFAULT:
                res_next.status_colour = COL_DANGER;
            ST_ALERT_PEND, ST_ALERT, ST_ALERT_CONFIRMED, ST_ALERT_MISMATCH,
            ST_ALERT_SENSORFAULT:
                res_next.status_colour = COL_ORANGE;
            default:
                res_next.status_colour = COL_NORMAL;
        endcase
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            code_reg        <= ST_NORMAL;
            mute_reg        <= 1'b0;
            alert_mark_reg  <= '0;
            danger_mark_reg <= '0;
            clear_mark_reg  <= '0;
            mis_mark_reg    <= '0;
            swf_reg         <= 1'b0;
            obs_reg         <= 1'b0;
            prev_reg        <= '0;
            res_reg         <= '0;
        end
        else if (step) begin
            code_reg        <= code_next;
            mute_reg        <= mute_next;
            alert_mark_reg  <= alert_mark_next;
            danger_mark_reg <= danger_mark_next;
            clear_mark_reg  <= clear_mark_next;
            mis_mark_reg    <= mis_mark_next;
            swf_reg         <= swf_next;
            obs_reg         <= obs_next;
            prev_reg        <= prev_next;
            res_reg         <= res_next;
        end
    end

    assign result = res_reg;

`ifndef SYNTH
    // obstruction event is sticky
    a_obs_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        obs_reg |=> obs_reg)
        else $error("obstruction flag dropped");

    // switch fault only raised from the danger mismatch state
    a_swf_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(swf_reg) |-> (code_reg == ST_DANGER_MISMATCH))
        else $error("switch fault raised outside danger mismatch");

    // alarm state moves only on a step
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(code_reg) && $stable(res_reg))
        else $error("alarm state changed without a word");
`endif

endmodule
